[design/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante, outside reset.
`define ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that cons holds in the cycle after ante, outside reset.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Check that cons holds in the cycle after ante, reset included.
`define ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[design/cbe_pkg.sv]
`timescale 1ns / 1ps
package cbe_pkg;

   // Defaults for the top-level parameters
   localparam int NEWTON_ROUNDS_DEF = 8;
   localparam int FRAC_BITS_DEF     = 16;

   // Field and port widths
   localparam int PROG_W  = 19;
   localparam int EASED_W = 19;
   localparam int TDATA_W = 24;
   localparam int CX_W    = 17;
   localparam int CY_W    = 19;
   localparam int CSR_AW  = 2;
   localparam int CSR_DW  = 19;

   // Register indexes
   localparam logic [CSR_AW-1:0] CSR_CTRL1_X = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_CTRL1_Y = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_CTRL2_X = 2'd2;
   localparam logic [CSR_AW-1:0] CSR_CTRL2_Y = 2'd3;

   // Register reset values
   localparam logic [CX_W-1:0]        CTRL1_X_RST = 17'd16384;
   localparam logic signed [CY_W-1:0] CTRL1_Y_RST = 19'sd6554;
   localparam logic [CX_W-1:0]        CTRL2_X_RST = 17'd16384;
   localparam logic signed [CY_W-1:0] CTRL2_Y_RST = 19'sd65536;

   // Output saturation limits
   localparam logic signed [EASED_W-1:0] EASED_MAX = 19'sh3FFFF;
   localparam logic signed [EASED_W-1:0] EASED_MIN = 19'sh40000;

   // Multiply program: curve terms first, slope terms after
   localparam int              PC_W          = 4;
   localparam logic [PC_W-1:0] PC_CURVE_LAST = 4'd7;
   localparam logic [PC_W-1:0] PC_DX_LAST    = 4'd13;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CHECK,
      ST_DIVIDE,
      ST_UPDATE,
      ST_DELIVER
   } state_type;

   typedef enum logic [1:0] {A_U, A_T, A_R} a_sel_type;
   typedef enum logic [2:0] {B_U, B_T, B_CA, B_CB, B_DIFX, B_OMX} b_sel_type;
   typedef enum logic {ACC_X, ACC_D} acc_dst_type;
   typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_mode_type;
   typedef enum logic [1:0] {K1, K3, K6} k_type;

   typedef struct packed {
      a_sel_type    a_sel;
      b_sel_type    b_sel;
      acc_dst_type  dst;
      acc_mode_type mode;
      k_type        k;
   } uop_type;

   typedef struct packed {
      logic            load_in;
      logic            run_uop;
      logic [PC_W-1:0] pc;
      logic            mode_y;
      logic            div_load;
      logic            div_step;
      logic            t_update;
      logic            load_out;
   } cmd_type;

   typedef struct packed {
      logic special_in;
      logic dx_zero;
   } sts_type;

   // One rounded product per step, result always lands in R
   function automatic uop_type uop_rom(input logic [PC_W-1:0] pc);
      uop_type u;
      u = '{A_U, B_U, ACC_X, ACC_HOLD, K1};
      unique case (pc)
         4'd0:  u = '{A_U, B_U,    ACC_X, ACC_HOLD, K1};
         4'd1:  u = '{A_R, B_T,    ACC_X, ACC_HOLD, K1};
         4'd2:  u = '{A_R, B_CA,   ACC_X, ACC_LOAD, K3};
         4'd3:  u = '{A_U, B_T,    ACC_X, ACC_HOLD, K1};
         4'd4:  u = '{A_R, B_T,    ACC_X, ACC_HOLD, K1};
         4'd5:  u = '{A_R, B_CB,   ACC_X, ACC_ADD,  K3};
         4'd6:  u = '{A_T, B_T,    ACC_X, ACC_HOLD, K1};
         4'd7:  u = '{A_R, B_T,    ACC_X, ACC_ADD,  K1};
         4'd8:  u = '{A_U, B_U,    ACC_D, ACC_HOLD, K1};
         4'd9:  u = '{A_R, B_CA,   ACC_D, ACC_LOAD, K3};
         4'd10: u = '{A_U, B_T,    ACC_D, ACC_HOLD, K1};
         4'd11: u = '{A_R, B_DIFX, ACC_D, ACC_ADD,  K6};
         4'd12: u = '{A_T, B_T,    ACC_D, ACC_HOLD, K1};
         4'd13: u = '{A_R, B_OMX,  ACC_D, ACC_ADD,  K3};
         default: u = '{A_U, B_U, ACC_X, ACC_HOLD, K1};
      endcase
      return u;
   endfunction

endpackage

[design/cubic_bezier_ease_core.sv]
`timescale 1ns / 1ps
// Cubic Bezier easing core. Each word on req carries a signed fixed-point
// progress value; the matching word on rsp carries y of the curve from
// (0,0) to (1,1) through the two control points held in the csr registers.
// Progress at or below zero returns 0 and at or above one returns one.
// Any other value runs NEWTON_ROUNDS Newton rounds on one shared
// multiplier and a bit-serial divider: each round runs the curve and slope
// multiply terms, one check, a divide of FRAC_BITS+2 quotient bits and one
// update, and the final y runs the curve terms once more; an item ends
// early when the slope reaches zero. Items are taken one at a time; a new
// word is accepted while the previous result still waits on rsp.
module cubic_bezier_ease_core #(
   parameter int NEWTON_ROUNDS = cbe_pkg::NEWTON_ROUNDS_DEF,
   parameter int FRAC_BITS     = cbe_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [cbe_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [cbe_pkg::CSR_DW-1:0]   csr_wdata,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [cbe_pkg::TDATA_W-1:0]  req_tdata,  // [18:0] progress
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [cbe_pkg::TDATA_W-1:0]  rsp_tdata   // [18:0] eased
);
   import cbe_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic signed [EASED_W-1:0] eased;

   cbe_ctrl #(
      .NEWTON_ROUNDS (NEWTON_ROUNDS),
      .FRAC_BITS     (FRAC_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   cbe_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .progress  (req_tdata[PROG_W-1:0]),
      .cmd       (cmd),
      .sts       (sts),
      .eased     (eased)
   );

   assign rsp_tdata = {{(TDATA_W - EASED_W){1'b0}}, eased};

endmodule

[design/cbe_datapath.sv]
`timescale 1ns / 1ps
module cbe_datapath #(
   parameter int FRAC_BITS = cbe_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [cbe_pkg::CSR_AW-1:0]          csr_addr,
   input  logic [cbe_pkg::CSR_DW-1:0]          csr_wdata,
   input  logic signed [cbe_pkg::PROG_W-1:0]   progress,
   input  cbe_pkg::cmd_type                    cmd,
   output cbe_pkg::sts_type                    sts,
   output logic signed [cbe_pkg::EASED_W-1:0]  eased
);
   import cbe_pkg::*;

   localparam int F  = FRAC_BITS;
   localparam int AW = F + 2;
   localparam int BW = (F + 2 > CY_W) ? F + 2 : CY_W;
   localparam int PW = AW + BW;
   localparam int RW = BW + 1;
   localparam int SW = BW + 6;
   localparam int DV = SW + F + 1;
   localparam int QW = F + 2;
   localparam int TW = F + 4;

   localparam logic signed [AW-1:0] ONE_A   = {2'b01, {F{1'b0}}};
   localparam logic signed [BW-1:0] ONE_B   = BW'(ONE_A);
   localparam logic signed [TW-1:0] ONE_T   = TW'(ONE_A);
   localparam logic [QW-1:0]        TWO_ONE = {2'b10, {F{1'b0}}};
   localparam logic [PW-1:0]        HALF    = PW'(1) << (F - 1);

   logic [CX_W-1:0]        c1x_ff, c2x_ff;
   logic signed [CY_W-1:0] c1y_ff, c2y_ff;
   logic signed [PROG_W-1:0] prog_ff;
   logic signed [AW-1:0] t_ff, t_in, u_ff, u_in;
   logic signed [RW-1:0] r_ff;
   logic signed [SW-1:0] acc_x_ff, acc_x_in, acc_d_ff, acc_d_in;
   logic [DV-1:0] rem_ff, rem_in, dsh_ff, dsh_in;
   logic [QW-1:0] q_ff, q_in;
   logic neg_ff, neg_in;
   logic spec_ff, spec_one_ff;
   logic signed [EASED_W-1:0] eased_ff, eased_in;

   uop_type uop;
   logic signed [BW-1:0] p1x, p2x, difx, omx, b_ca, b_cb, b_op, prog_b;
   logic signed [AW-1:0] a_op;
   logic signed [PW-1:0] prod;
   logic [PW-1:0] mag, rnd;
   logic signed [RW-1:0] rq;
   logic signed [SW-1:0] kq_1, kq_3, kq_k, acc_sel;
   logic signed [SW:0] xp;
   logic [SW-1:0] nmag, dmag;
   logic ge;
   logic [QW-1:0] qsat;
   logic signed [TW-1:0] delta, tn;
   logic signed [AW-1:0] t_clamp, t_load;
   logic signed [SW-1:0] result;
   logic le0, ge1;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         c1x_ff <= CTRL1_X_RST;
         c1y_ff <= CTRL1_Y_RST;
         c2x_ff <= CTRL2_X_RST;
         c2y_ff <= CTRL2_Y_RST;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_CTRL1_X: c1x_ff <= csr_wdata[CX_W-1:0];
            CSR_CTRL1_Y: c1y_ff <= csr_wdata;
            CSR_CTRL2_X: c2x_ff <= csr_wdata[CX_W-1:0];
            CSR_CTRL2_Y: c2y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Classify the incoming word
   assign prog_b = BW'(progress);
   assign le0    = (prog_b <= 0);
   assign ge1    = (prog_b >= ONE_B);
   assign sts.special_in = le0 | ge1;
   assign sts.dx_zero    = (acc_d_ff == '0);

   // Select multiplier operands
   assign uop  = uop_rom(cmd.pc);
   assign p1x  = BW'($signed({1'b0, c1x_ff}));
   assign p2x  = BW'($signed({1'b0, c2x_ff}));
   assign difx = p2x - p1x;
   assign omx  = ONE_B - p2x;
   assign b_ca = cmd.mode_y ? BW'(c1y_ff) : p1x;
   assign b_cb = cmd.mode_y ? BW'(c2y_ff) : p2x;

   always_comb begin
      unique case (uop.a_sel)
         A_U:     a_op = u_ff;
         A_T:     a_op = t_ff;
         A_R:     a_op = r_ff[AW-1:0];
         default: a_op = u_ff;
      endcase
      unique case (uop.b_sel)
         B_U:     b_op = BW'(u_ff);
         B_T:     b_op = BW'(t_ff);
         B_CA:    b_op = b_ca;
         B_CB:    b_op = b_cb;
         B_DIFX:  b_op = difx;
         B_OMX:   b_op = omx;
         default: b_op = BW'(u_ff);
      endcase
   end

   // Multiply and round to nearest, ties away from zero
   assign prod = PW'(a_op) * PW'(b_op);
   assign mag  = prod[PW-1] ? $unsigned(-prod) : $unsigned(prod);
   assign rnd  = (mag + HALF) >> F;
   assign rq   = prod[PW-1] ? -$signed(rnd[RW-1:0]) : $signed(rnd[RW-1:0]);

   // Scale by the term factor and accumulate
   assign kq_1 = SW'(rq);
   assign kq_3 = kq_1 + (kq_1 <<< 1);
   always_comb begin
      unique case (uop.k)
         K1:      kq_k = kq_1;
         K3:      kq_k = kq_3;
         K6:      kq_k = kq_3 <<< 1;
         default: kq_k = kq_1;
      endcase
      acc_sel  = (uop.dst == ACC_X) ? acc_x_ff : acc_d_ff;
      acc_x_in = acc_x_ff;
      acc_d_in = acc_d_ff;
      if (cmd.run_uop && uop.mode != ACC_HOLD) begin
         if (uop.dst == ACC_X) begin
            acc_x_in = (uop.mode == ACC_LOAD) ? kq_k : acc_sel + kq_k;
         end else begin
            acc_d_in = (uop.mode == ACC_LOAD) ? kq_k : acc_sel + kq_k;
         end
      end
   end

   // Set up and step the restoring divider
   assign xp   = (SW + 1)'(acc_x_ff) - (SW + 1)'(prog_ff);
   assign nmag = xp[SW] ? SW'(-xp) : SW'(xp);
   assign dmag = acc_d_ff[SW-1] ? $unsigned(-acc_d_ff) : $unsigned(acc_d_ff);
   assign ge   = (rem_ff >= dsh_ff);

   always_comb begin
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      q_in   = q_ff;
      neg_in = neg_ff;
      if (cmd.div_load) begin
         rem_in = {1'b0, nmag, {F{1'b0}}};
         dsh_in = {dmag, {(F + 1){1'b0}}};
         q_in   = '0;
         neg_in = xp[SW] ^ acc_d_ff[SW-1];
      end else if (cmd.div_step) begin
         rem_in = ge ? rem_ff - dsh_ff : rem_ff;
         dsh_in = dsh_ff >> 1;
         q_in   = {q_ff[QW-2:0], ge};
      end
   end

   // Apply the saturated step and clamp t to the unit range
   assign qsat  = (q_ff > TWO_ONE) ? TWO_ONE : q_ff;
   assign delta = neg_ff ? -TW'({1'b0, qsat}) : TW'({1'b0, qsat});
   assign tn    = TW'(t_ff) - delta;
   assign t_clamp = (tn < 0) ? '0 : ((tn > ONE_T) ? ONE_A : tn[AW-1:0]);
   assign t_load  = AW'(progress);

   always_comb begin
      t_in = t_ff;
      u_in = u_ff;
      if (cmd.load_in) begin
         t_in = t_load;
         u_in = ONE_A - t_load;
      end else if (cmd.t_update) begin
         t_in = t_clamp;
         u_in = ONE_A - t_clamp;
      end
   end

   // Pick the answer and saturate to the output range
   always_comb begin
      if (spec_ff) begin
         result = spec_one_ff ? SW'(ONE_B) : '0;
      end else begin
         result = acc_x_ff;
      end
      if (result > SW'(EASED_MAX)) begin
         eased_in = EASED_MAX;
      end else if (result < SW'(EASED_MIN)) begin
         eased_in = EASED_MIN;
      end else begin
         eased_in = result[EASED_W-1:0];
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      t_ff     <= t_in;
      u_ff     <= u_in;
      acc_x_ff <= acc_x_in;
      acc_d_ff <= acc_d_in;
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      q_ff     <= q_in;
      neg_ff   <= neg_in;
      if (cmd.run_uop) begin
         r_ff <= rq;
      end
      if (cmd.load_in) begin
         prog_ff     <= progress;
         spec_ff     <= le0 | ge1;
         spec_one_ff <= ge1;
      end
      if (cmd.load_out) begin
         eased_ff <= eased_in;
      end
   end

   assign eased = eased_ff;

endmodule

[design/cbe_ctrl.sv]
`timescale 1ns / 1ps
module cbe_ctrl #(
   parameter int NEWTON_ROUNDS = cbe_pkg::NEWTON_ROUNDS_DEF,
   parameter int FRAC_BITS     = cbe_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  cbe_pkg::sts_type sts,
   output cbe_pkg::cmd_type cmd
);
   import cbe_pkg::*;

   localparam int DCW = $clog2(FRAC_BITS + 2);
   localparam int RCW = $clog2(NEWTON_ROUNDS + 1);
   localparam logic [DCW-1:0] DIV_LAST = DCW'(FRAC_BITS + 1);
   localparam logic [RCW-1:0] RND_LAST = RCW'(NEWTON_ROUNDS - 1);

   state_type state_ff, state_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic mode_ff, mode_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic [RCW-1:0] rnd_ff, rnd_in;
   logic valid_ff, valid_in;
   logic pc_last, can_load;

   assign pc_last  = (pc_ff == (mode_ff ? PC_CURVE_LAST : PC_DX_LAST));
   assign can_load = !valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = sts.special_in ? ST_DELIVER : ST_MUL;
            end
         end
         ST_MUL: begin
            if (pc_last) begin
               state_in = mode_ff ? ST_DELIVER : ST_CHECK;
            end
         end
         ST_CHECK:  state_in = sts.dx_zero ? ST_MUL : ST_DIVIDE;
         ST_DIVIDE: begin
            if (dcnt_ff == DIV_LAST) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: state_in = ST_MUL;
         ST_DELIVER: begin
            if (can_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      cmd.pc     = pc_ff;
      cmd.mode_y = mode_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.load_in = req_tvalid;
         end
         ST_MUL:     cmd.run_uop  = 1'b1;
         ST_CHECK:   cmd.div_load = !sts.dx_zero;
         ST_DIVIDE:  cmd.div_step = 1'b1;
         ST_UPDATE:  cmd.t_update = 1'b1;
         ST_DELIVER: cmd.load_out = can_load;
         default: ;
      endcase
   end

   // Advance the program, divide and round counters
   always_comb begin
      pc_in   = pc_ff;
      mode_in = mode_ff;
      dcnt_in = dcnt_ff;
      rnd_in  = rnd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            pc_in   = '0;
            mode_in = 1'b0;
            rnd_in  = '0;
         end
         ST_MUL:   pc_in = pc_last ? '0 : pc_ff + 1'b1;
         ST_CHECK: begin
            dcnt_in = '0;
            if (sts.dx_zero) begin
               mode_in = 1'b1;
            end
         end
         ST_DIVIDE: dcnt_in = dcnt_ff + 1'b1;
         ST_UPDATE: begin
            if (rnd_ff == RND_LAST) begin
               mode_in = 1'b1;
            end else begin
               rnd_in = rnd_ff + 1'b1;
            end
         end
         ST_DELIVER: ;
         default: ;
      endcase
   end

   // Output word valid: set on load, drop when taken
   always_comb begin
      valid_in = valid_ff;
      if (cmd.load_out) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         mode_ff  <= 1'b0;
         dcnt_ff  <= '0;
         rnd_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         mode_ff  <= mode_in;
         dcnt_ff  <= dcnt_in;
         rnd_ff   <= rnd_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

[design/cbe_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cbe_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic [cbe_pkg::TDATA_W-1:0]  req_tdata,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [cbe_pkg::TDATA_W-1:0]  rsp_tdata
);
   import cbe_pkg::*;

   // A stalled result word stays up and unchanged
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))

   // Pad bits above the result field stay zero
   `ASSERT_SAME(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[TDATA_W-1:EASED_W] == '0)

   // Reset leaves no result pending
   `ASSERT_NEXT_ALWAYS(a_rsp_reset, clock, reset, !rsp_tvalid)

   // Check that the input is closed in the cycle after each accepted word
   `ASSERT_NEXT(a_rsp_busy, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

bind cubic_bezier_ease_core cbe_checker u_cbe_checker (.*);
